// ===== design/dgrc_pkg.sv =====
// Package for the column ray caster: payload structs, fixed-point constants
// and register indexes. No dependencies.
package dgrc_pkg;

	localparam int MAP_SIDE_DEF = 16;
	localparam int SCREEN_COLUMNS_DEF = 320;
	localparam int SCREEN_ROWS_DEF = 240;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_D = 2'd3;

	typedef struct packed {
		logic [8:0]         column;
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
	} ray_req_t;

	typedef struct packed {
		logic [8:0]  out_column;
		logic [7:0]  span_start;
		logic [7:0]  span_end;
		logic        side_hit;
		logic [3:0]  cell_x;
		logic [3:0]  cell_y;
		logic [15:0] perp_distance;
		logic [7:0]  shade_red;
		logic        escaped;
	} ray_res_t;

	// Handshake between the sequencer and the shared divider.
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== design/dgrc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dgrc_pkg.
module dgrc_div #(
	parameter int NW = 47,
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dgrc_pkg::div_ctl_t   ctl,
	input  logic [NW-1:0]        num,
	input  logic [DW-1:0]        den,
	output dgrc_pkg::div_sts_t   sts,
	output logic [NW-1:0]        quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   den_ext;

	assign den_ext = {1'b0, den};
	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};

	// Shift in one numerator bit, subtract the divisor when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= den_ext) begin
				rem_q <= trial - den_ext;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo = quo_q;
endmodule

// ===== design/dda_grid_raycast_column.sv =====
// Column ray caster: one request is a screen column plus camera, one result
// is the wall slice for that column. The block handles one request at a time.
// Setup passes ST_CAM, ST_RX, ST_RY and ST_INIT, then each DDA cell step runs
// ST_MUL1, ST_MUL2 and ST_STEP: one shared 32x18 multiplier forms each cross
// product of the step compare, then the step is taken and tested. A ray leaves
// the grid within about 32 steps, and the guard stops the walk at 64. An escaped
// ray goes from ST_DDIV straight to ST_SPAN. A hit adds two passes of the shared
// bit-serial divider, wall distance and then line height; each pass forms 47
// quotient bits. ST_SPAN finishes the slice, and the block then returns to idle
// before the next request is taken. A result waits in an output register, and
// the next request can be taken meanwhile. A newer slice waits to finish until
// the older one has gone.
module dda_grid_raycast_column #(
	parameter int MAP_SIDE = dgrc_pkg::MAP_SIDE_DEF,
	parameter int SCREEN_COLUMNS = dgrc_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS = dgrc_pkg::SCREEN_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dgrc_pkg::ray_req_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dgrc_pkg::ray_res_t  out_data,
	input  logic                cfg_we,
	input  logic [dgrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]         cfg_data
);
	localparam int NW = 47;
	localparam int DW = 32;
	localparam int GUARD = 4 * MAP_SIDE;
	localparam int GW = $clog2(GUARD + 1);
	localparam int ROW_HALF = SCREEN_ROWS / 2;
	localparam logic [NW-1:0] HNUM = NW'(SCREEN_ROWS * 2048);
	// Reciprocal of the column count, exact for numerators below 2^24.
	localparam int CAM_L = $clog2(SCREEN_COLUMNS);
	localparam int CAM_S = 24 + CAM_L;
	localparam longint CAM_R =
		((longint'(1) <<< CAM_S) + longint'(SCREEN_COLUMNS) - 1) / longint'(SCREEN_COLUMNS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CAM, ST_RX, ST_RY, ST_INIT, ST_MUL1, ST_MUL2,
		ST_STEP, ST_DDIV, ST_DWAIT, ST_HDIV, ST_HWAIT, ST_SPAN
	} state_t;

	state_t state_q;
	dgrc_pkg::ray_req_t req_q;
	dgrc_pkg::ray_res_t res_q;
	logic out_valid_q;
	logic span_go;
	logic [63:0] map_q [4];

	logic signed [16:0] cam_q;
	logic signed [31:0] rx_q, ry_q;
	logic [31:0] ax_q, ay_q;
	logic signed [5:0] mx_q, my_q;
	logic [17:0] tx_q, ty_q;
	logic [GW-1:0] guard_q;
	logic side_q;
	logic [49:0] prod_q;
	logic [15:0] dist_q;
	logic [16:0] h_q;
	logic state_esc_q;

	// Shared multiplier operands.
	logic [31:0] mul_a;
	logic [17:0] mul_b;
	logic [49:0] mul_p;
	logic signed [33:0] smul_p;
	logic signed [16:0] sm_a;
	logic signed [16:0] sm_b;

	dgrc_pkg::div_ctl_t div_ctl;
	dgrc_pkg::div_sts_t div_sts;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) map_q[i] <= '0;
		end else if (cfg_we) begin
			map_q[cfg_index] <= cfg_data;
		end
	end

	// Camera coordinate: floor(2*col*2^14/COLUMNS) - 2^14 by reciprocal
	// multiplication, done once per request.
	logic [34:0] cam_prod;
	logic [16:0] cam_div;
	assign cam_prod = 35'(req_q.column) * 35'(CAM_R);
	assign cam_div = 17'(cam_prod >> (CAM_S - 15));

	// Signed multiplier for ray direction, unsigned for the step compare.
	assign smul_p = sm_a * sm_b;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		sm_a = 17'sd0;
		sm_b = 17'sd0;
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_RX) begin
			sm_a = 17'(req_q.plane_x);
			sm_b = cam_q;
		end else if (state_q == ST_RY) begin
			sm_a = 17'(req_q.plane_y);
			sm_b = cam_q;
		end
		if (state_q == ST_MUL1) begin
			mul_a = ay_q;
			mul_b = tx_q;
		end else begin
			mul_a = ax_q;
			mul_b = ty_q;
		end
	end

	// Wall lookup for the current cell.
	logic wall;
	logic [63:0] wword;
	logic [5:0] wbit;
	assign wword = map_q[mx_q[3:2]];
	assign wbit = {mx_q[1:0], my_q[3:0]};
	assign wall = wword[wbit];

	logic in_grid;
	assign in_grid = (mx_q >= 0) && (mx_q < 6'(MAP_SIDE)) &&
		(my_q >= 0) && (my_q < 6'(MAP_SIDE));

	logic signed [5:0] nmx, nmy;
	assign nmx = rx_q[31] ? mx_q - 6'sd1 : mx_q + 6'sd1;
	assign nmy = ry_q[31] ? my_q - 6'sd1 : my_q + 6'sd1;

	logic [16:0] hh;
	assign hh = h_q >> 1;

	// A finished slice may enter the output register once it is free.
	assign span_go = !out_valid_q || out_ready;

	// Main sequencer and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SPAN && span_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CAM;
				ST_CAM: state_q <= ST_RX;
				ST_RX: state_q <= ST_RY;
				ST_RY: state_q <= ST_INIT;
				ST_INIT: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_STEP;
				ST_STEP: begin
					if (!in_grid || wall || guard_q == GW'(GUARD)) state_q <= ST_DDIV;
					else state_q <= ST_MUL1;
				end
				ST_DDIV: state_q <= (!in_grid || !wall) ? ST_SPAN : ST_DWAIT;
				ST_DWAIT: if (div_sts.done) state_q <= ST_HDIV;
				ST_HDIV: state_q <= ST_HWAIT;
				ST_HWAIT: if (div_sts.done) state_q <= ST_SPAN;
				ST_SPAN: if (span_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= in_data;
				guard_q <= '0;
				side_q <= 1'b0;
			end
			ST_CAM: cam_q <= 17'(cam_div) - 17'd16384;
			ST_RX: rx_q <= 32'(signed'(req_q.view_dir_x)) * 32'sd16384 + 32'(smul_p);
			ST_RY: ry_q <= 32'(signed'(req_q.view_dir_y)) * 32'sd16384 + 32'(smul_p);
			ST_INIT: begin
				ax_q <= rx_q[31] ? 32'(-rx_q) : 32'(rx_q);
				ay_q <= ry_q[31] ? 32'(-ry_q) : 32'(ry_q);
				mx_q <= 6'({2'b00, req_q.pos_x[15:12]});
				my_q <= 6'({2'b00, req_q.pos_y[15:12]});
				tx_q <= rx_q[31] ? 18'({6'd0, req_q.pos_x[11:0]}) :
					18'(17'd4096 - 17'({5'd0, req_q.pos_x[11:0]}));
				ty_q <= ry_q[31] ? 18'({6'd0, req_q.pos_y[11:0]}) :
					18'(17'd4096 - 17'({5'd0, req_q.pos_y[11:0]}));
			end
			ST_MUL1: prod_q <= mul_p;
			ST_MUL2: begin
				guard_q <= guard_q + 1'b1;
				if (prod_q < mul_p) begin
					mx_q <= nmx;
					tx_q <= tx_q + 18'd4096;
					side_q <= 1'b0;
				end else begin
					my_q <= nmy;
					ty_q <= ty_q + 18'd4096;
					side_q <= 1'b1;
				end
			end
			ST_DDIV: begin
				dist_q <= 16'hFFFF;
			end
			ST_DWAIT: begin
				if (div_sts.done) begin
					if (div_den == '0 || div_quo > NW'(16'hFFFF)) dist_q <= 16'hFFFF;
					else dist_q <= div_quo[15:0];
				end
			end
			ST_HWAIT: begin
				if (div_sts.done) begin
					if (dist_q == '0 || div_quo > NW'(16'hFFFF)) h_q <= 17'hFFFF;
					else h_q <= div_quo[16:0];
				end
			end
			ST_SPAN: if (span_go) begin
				res_q.out_column <= req_q.column;
				res_q.side_hit <= side_q;
				if (state_esc_q) begin
					res_q.span_start <= '0;
					res_q.span_end <= '0;
					res_q.cell_x <= '0;
					res_q.cell_y <= '0;
					res_q.perp_distance <= 16'hFFFF;
					res_q.shade_red <= '0;
					res_q.escaped <= 1'b1;
				end else begin
					res_q.span_start <= (hh > 17'(ROW_HALF)) ? 8'd0 :
						8'(17'(ROW_HALF) - hh);
					res_q.span_end <= (hh + 17'(ROW_HALF) >= 17'(SCREEN_ROWS)) ?
						8'(SCREEN_ROWS - 1) : 8'(hh + 17'(ROW_HALF));
					res_q.cell_x <= mx_q[3:0];
					res_q.cell_y <= my_q[3:0];
					res_q.perp_distance <= dist_q;
					res_q.shade_red <= dist_q[15] ? 8'd0 :
						((16'h8000 - dist_q) > 16'h7FFF) ? 8'hFF :
						8'((16'h8000 - dist_q) >> 7);
					res_q.escaped <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Escape flag, set when the walk ends outside the grid or without a hit.
	always_ff @(posedge clk) begin
		if (state_q == ST_DDIV) state_esc_q <= !in_grid || !wall;
	end

	// Divider operands: wall distance first, then line height.
	logic [17:0] t_sel;
	assign t_sel = (side_q ? ty_q : tx_q) - 18'd4096;
	always_comb begin
		div_ctl.start = (state_q == ST_DDIV && in_grid && wall) || (state_q == ST_HDIV);
		if (state_q == ST_HDIV || state_q == ST_HWAIT) begin
			div_num = HNUM;
			div_den = 32'(dist_q);
		end else begin
			div_num = NW'({t_sel[11:0], 27'd0}) | NW'({t_sel[17:12], 39'd0});
			div_den = side_q ? ay_q : ax_q;
		end
	end

	dgrc_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl),
		.num(div_num), .den(div_den), .sts(div_sts), .quo(div_quo)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = res_q;
endmodule

// ===== design/dgrc_checker.sv =====
// Port-level checks for the column ray caster, bound to the top level.
// Depends on dgrc_pkg.
module dgrc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input dgrc_pkg::ray_res_t out_data
);
	// The block is busy right after it takes a request.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after a request");

	// A waiting result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Escaped results carry saturated distance.
	a_esc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.escaped |-> out_data.perp_distance == 16'hFFFF)
		else $error("escaped result without saturated distance");

	// Escaped results carry an empty span and no shade.
	a_esc_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.escaped |-> out_data.span_start == 8'd0 &&
		out_data.span_end == 8'd0 && out_data.shade_red == 8'd0)
		else $error("escaped result with a span");
endmodule

bind dda_grid_raycast_column dgrc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
